// ===== hw/rtl/iest_pkg.sv =====
// Shared types, request codes and saturating arithmetic for the input event state tracker.
`timescale 1ns / 1ps
package iest_pkg;

	localparam logic [3:0] REQ_FRAME    = 4'd0;
	localparam logic [3:0] REQ_FOCUS_ON = 4'd1;
	localparam logic [3:0] REQ_FOCUS_OFF = 4'd2;
	localparam logic [3:0] REQ_DEV_RST  = 4'd3;
	localparam logic [3:0] REQ_KEY_DN   = 4'd4;
	localparam logic [3:0] REQ_KEY_UP   = 4'd5;
	localparam logic [3:0] REQ_KEY_RPT  = 4'd6;
	localparam logic [3:0] REQ_MOVE     = 4'd7;
	localparam logic [3:0] REQ_BTN_DN   = 4'd8;
	localparam logic [3:0] REQ_BTN_UP   = 4'd9;
	localparam logic [3:0] REQ_WHEEL    = 4'd10;

	localparam int KEY_CODE_W = 8;
	localparam int BTN_CODE_W = 3;
	localparam logic [31:0] REP_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [3:0]         req_type;
		logic [7:0]         key_code;
		logic [2:0]         button_code;
		logic signed [31:0] event_x;
		logic signed [31:0] event_y;
		logic signed [31:0] wheel_step;
		logic               keyboard_capture_in;
		logic               mouse_capture_in;
	} evt_t;

	typedef struct packed {
		logic [2:0]         key_flags;
		logic [31:0]        key_rpt_cnt;
		logic [2:0]         button_flags;
		logic [3:0]         status_flags;
		logic signed [31:0] cursor_x;
		logic signed [31:0] cursor_y;
		logic signed [31:0] delta_x;
		logic signed [31:0] delta_y;
		logic signed [31:0] wheel_total;
	} res_t;

	typedef struct packed {
		logic        held;
		logic        press;
		logic        rel;
		logic [31:0] reps;
	} key_entry_t;

	typedef struct packed {
		logic                  accept;
		logic                  exec;
		logic                  init_wr;
		logic                  swp_rd;
		logic [KEY_CODE_W-1:0] addr;
		logic                  key_rd;
		logic                  key_fin;
		logic                  out_load;
	} iest_cmd_t;

	typedef struct packed {
		logic sweep_req;
		logic out_free;
	} iest_sts_t;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [32:0] b);
		logic signed [33:0] s;
		s = $signed({{2{a[31]}}, a}) + $signed({b[32], b});
		if (s > 34'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (s < -34'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

endpackage

// ===== hw/rtl/iest_ctrl.sv =====
// Sequencer for the input event state tracker: reset clear, sweeps, key access, result hand-off.
`timescale 1ns / 1ps
module iest_ctrl import iest_pkg::*; #(
	parameter int KEY_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  iest_sts_t sts,
	output iest_cmd_t cmd
);

	localparam int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam logic [KA-1:0] LAST = KA'(KEY_DEPTH - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_KRD   = 3'd5;
	localparam logic [2:0] ST_KFIN  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]    state_q, state_d;
	logic [KA-1:0] cnt_q, cnt_d;

	assign evt_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.addr = KEY_CODE_W'(cnt_q);
		unique case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					cnt_d = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (evt_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cnt_d = '0;
				state_d = sts.sweep_req ? ST_SWEEP : ST_KRD;
			end
			ST_SWEEP: begin
				cmd.swp_rd = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					cnt_d = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_KRD;
			ST_KRD: begin
				cmd.key_rd = 1'b1;
				state_d = ST_KFIN;
			end
			ST_KFIN: begin
				cmd.key_fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ===== hw/rtl/iest_dp.sv =====
// Datapath for the input event state tracker: key table, button flags, mouse state, result register.
`timescale 1ns / 1ps
module iest_dp import iest_pkg::*; #(
	parameter int NUM_KEYS    = 256,
	parameter int NUM_BUTTONS = 8,
	parameter int KEY_DEPTH   = 256,
	parameter int BTN_DEPTH   = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  evt_t      evt,
	input  iest_cmd_t cmd,
	output iest_sts_t sts,
	output logic      res_valid,
	input  logic      res_ready,
	output res_t      res
);

	localparam int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int BA = (BTN_DEPTH > 1) ? $clog2(BTN_DEPTH) : 1;

	evt_t       req_q;
	key_entry_t key_mem [KEY_DEPTH];
	key_entry_t rdata_q, kres_q, kmod;
	logic       swp_s1;
	logic [KA-1:0] addr_s1;
	logic       clr_q, drop_q, keyop_q;

	logic [BTN_DEPTH-1:0] bheld_q, bpress_q, brel_q;
	logic focus_q, posv_q, kcap_q, mcap_q;
	logic signed [31:0] lx_q, ly_q, dx_q, dy_q, wh_q;
	logic res_valid_q;
	res_t res_q;

	logic key_ok, btn_ok, rd_en, wr_en;
	logic [KA-1:0] kidx, rd_addr, wr_addr;
	logic [BA-1:0] bidx;
	key_entry_t wdata, swp_w;

	assign key_ok = (req_q.key_code != '0) && (32'(req_q.key_code) < NUM_KEYS);
	assign btn_ok = (req_q.button_code != '0) && (32'(req_q.button_code) < NUM_BUTTONS);
	assign kidx = req_q.key_code[KA-1:0];
	assign bidx = req_q.button_code[BA-1:0];

	assign sts.sweep_req = (req_q.req_type == REQ_FRAME) || (req_q.req_type == REQ_FOCUS_OFF)
		|| (req_q.req_type == REQ_DEV_RST);
	assign sts.out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= evt;
		end
	end

	always_comb begin
		swp_w.held = rdata_q.held & ~drop_q;
		swp_w.press = rdata_q.press & ~clr_q;
		swp_w.rel = (rdata_q.rel & ~clr_q) | (rdata_q.held & drop_q);
		swp_w.reps = clr_q ? '0 : rdata_q.reps;
	end

	always_comb begin
		kmod = rdata_q;
		if (keyop_q) begin
			unique case (req_q.req_type)
				REQ_KEY_DN: begin
					kmod.press = rdata_q.press | ~rdata_q.held;
					kmod.held = 1'b1;
				end
				REQ_KEY_UP: begin
					kmod.rel = rdata_q.rel | rdata_q.held;
					kmod.held = 1'b0;
				end
				default: begin
					if (rdata_q.held && rdata_q.reps != REP_MAX) begin
						kmod.reps = rdata_q.reps + 32'd1;
					end
				end
			endcase
		end
	end

	assign rd_en = cmd.swp_rd || cmd.key_rd;
	assign rd_addr = cmd.swp_rd ? cmd.addr[KA-1:0] : kidx;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = kidx;
		wdata = kmod;
		priority if (cmd.init_wr) begin
			wr_en = 1'b1;
			wr_addr = cmd.addr[KA-1:0];
			wdata = '0;
		end else if (swp_s1) begin
			wr_en = 1'b1;
			wr_addr = addr_s1;
			wdata = swp_w;
		end else begin
			wr_en = cmd.key_fin && keyop_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= key_mem[rd_addr];
		end
		addr_s1 <= cmd.addr[KA-1:0];
		if (cmd.key_fin) begin
			kres_q <= kmod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swp_s1 <= 1'b0;
		end else begin
			swp_s1 <= cmd.swp_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bheld_q <= '0;
			bpress_q <= '0;
			brel_q <= '0;
			focus_q <= 1'b0;
			posv_q <= 1'b0;
			kcap_q <= 1'b0;
			mcap_q <= 1'b0;
			lx_q <= '0;
			ly_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			wh_q <= '0;
			clr_q <= 1'b0;
			drop_q <= 1'b0;
			keyop_q <= 1'b0;
		end else if (cmd.exec) begin
			clr_q <= (req_q.req_type == REQ_FRAME);
			drop_q <= (req_q.req_type == REQ_FOCUS_OFF) || (req_q.req_type == REQ_DEV_RST)
				|| ((req_q.req_type == REQ_FRAME) && req_q.keyboard_capture_in && !kcap_q);
			keyop_q <= focus_q && !kcap_q && key_ok && ((req_q.req_type == REQ_KEY_DN)
				|| (req_q.req_type == REQ_KEY_UP) || (req_q.req_type == REQ_KEY_RPT));
			priority if (req_q.req_type == REQ_FRAME) begin
				bpress_q <= '0;
				brel_q <= '0;
				dx_q <= '0;
				dy_q <= '0;
				wh_q <= '0;
				if (req_q.mouse_capture_in && !mcap_q) begin
					bheld_q <= '0;
					brel_q <= bheld_q;
					posv_q <= 1'b0;
				end
				kcap_q <= req_q.keyboard_capture_in;
				mcap_q <= req_q.mouse_capture_in;
			end else if (req_q.req_type == REQ_FOCUS_ON) begin
				focus_q <= 1'b1;
				posv_q <= 1'b0;
				dx_q <= '0;
				dy_q <= '0;
			end else if ((req_q.req_type == REQ_FOCUS_OFF) || (req_q.req_type == REQ_DEV_RST)) begin
				bheld_q <= '0;
				brel_q <= brel_q | bheld_q;
				posv_q <= 1'b0;
				dx_q <= '0;
				dy_q <= '0;
				if (req_q.req_type == REQ_FOCUS_OFF) begin
					focus_q <= 1'b0;
				end
			end else if (focus_q && (req_q.req_type >= REQ_MOVE)
				&& (req_q.req_type <= REQ_WHEEL)) begin
				if (mcap_q) begin
					posv_q <= 1'b0;
					dx_q <= '0;
					dy_q <= '0;
				end else begin
					if (posv_q) begin
						dx_q <= sat_add(dx_q, $signed({req_q.event_x[31], req_q.event_x})
							- $signed({lx_q[31], lx_q}));
						dy_q <= sat_add(dy_q, $signed({req_q.event_y[31], req_q.event_y})
							- $signed({ly_q[31], ly_q}));
					end
					lx_q <= req_q.event_x;
					ly_q <= req_q.event_y;
					posv_q <= 1'b1;
					if (req_q.req_type == REQ_WHEEL) begin
						wh_q <= sat_add(wh_q, $signed({req_q.wheel_step[31], req_q.wheel_step}));
					end else if (btn_ok && (req_q.req_type == REQ_BTN_DN)) begin
						bpress_q[bidx] <= bpress_q[bidx] | ~bheld_q[bidx];
						bheld_q[bidx] <= 1'b1;
					end else if (btn_ok && (req_q.req_type == REQ_BTN_UP)) begin
						brel_q[bidx] <= brel_q[bidx] | bheld_q[bidx];
						bheld_q[bidx] <= 1'b0;
					end
				end
			end else begin
				// hold
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.key_flags <= key_ok ? {kres_q.rel, kres_q.press, kres_q.held} : 3'd0;
			res_q.key_rpt_cnt <= key_ok ? kres_q.reps : 32'd0;
			res_q.button_flags <= btn_ok ? {brel_q[bidx], bpress_q[bidx], bheld_q[bidx]} : 3'd0;
			res_q.status_flags <= {mcap_q, kcap_q, posv_q, focus_q};
			res_q.cursor_x <= lx_q;
			res_q.cursor_y <= ly_q;
			res_q.delta_x <= dx_q;
			res_q.delta_y <= dy_q;
			res_q.wheel_total <= wh_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ===== hw/rtl/input_event_state_tracker_top.sv =====
// Top level of the input event state tracker.
//
// Channels: evt (request in, evt_t) and res (result out, res_t), both valid/ready.
// Every request returns exactly one result: the flags and repeat count of the named key,
// the flags of the named button, and the focus, capture and mouse values after the event.
// Key, mouse and query requests pass from accept through the exec, key read, key finish
// and output states to res_valid.
// Frame start, focus lost and device reset sweep the key table, one entry per cycle,
// through its single read and write port, and then pass through the drain, key read,
// key finish and output states.
// One request is in flight at a time; evt_ready is high only between requests.
// Reset: button, focus, capture and mouse state clear at once; the key table is cleared by
// a pass over all KEY_DEPTH entries after reset release; evt_ready stays low during it.
// A stalled receiver holds the result register; the next request may still be taken,
// and its result waits until the register is free.
`timescale 1ns / 1ps
module input_event_state_tracker_top import iest_pkg::*; #(
	parameter int NUM_KEYS    = 256,
	parameter int NUM_BUTTONS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_ready,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int KEY_DEPTH = (NUM_KEYS > 256) ? 256 : NUM_KEYS;
	localparam int BTN_DEPTH = (NUM_BUTTONS > 8) ? 8 : NUM_BUTTONS;

	iest_cmd_t cmd;
	iest_sts_t sts;

	iest_ctrl #(
		.KEY_DEPTH(KEY_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.sts(sts),
		.cmd(cmd)
	);

	iest_dp #(
		.NUM_KEYS(NUM_KEYS),
		.NUM_BUTTONS(NUM_BUTTONS),
		.KEY_DEPTH(KEY_DEPTH),
		.BTN_DEPTH(BTN_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.cmd(cmd),
		.sts(sts),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

endmodule

// ===== hw/rtl/iest_checker.sv =====
// Port-level checks for the input event state tracker and their binding to the top level.
`timescale 1ns / 1ps
module iest_checker import iest_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_ready,
	input evt_t evt,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt))
		else $error("request dropped or changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("request taken while another is in flight");

	a_key_press: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.key_flags[1] && !res.key_flags[0] && !res.key_flags[2]))
		else $error("key pressed mark without held or released");

	a_btn_press: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.button_flags[1] && !res.button_flags[0] && !res.button_flags[2]))
		else $error("button pressed mark without held or released");

endmodule

bind input_event_state_tracker_top iest_checker u_iest_checker (
	.clk(clk),
	.arst_n(arst_n),
	.evt_valid(evt_valid),
	.evt_ready(evt_ready),
	.evt(evt),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res(res)
);
